// ===== src/point_in_polygon_test_unit_assert.svh =====
// Assertion macros for the point-in-polygon test unit.
`ifndef POINT_IN_POLYGON_TEST_UNIT_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_UNIT_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define PPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define PPT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== src/ppt_pkg.sv =====
// Shared types and constants of the point-in-polygon test unit.
`default_nettype none

package ppt_pkg;

  localparam int unsigned COORD_W          = 16;
  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned QUEUE_DEPTH      = 2;

  typedef struct packed {
    logic                      func;
    logic                      restart;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } in_word_t;

  typedef struct packed {
    logic inside_res;
    logic overflowed;
  } out_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vertex_t;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_RESTART,
    OP_QUERY
  } op_e;

  typedef struct packed {
    op_e     op;
    vertex_t pt;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic busy;
    logic pop;
    logic full;
    logic over;
    logic ovf;
  } back_stat_t;

endpackage

`default_nettype wire

// ===== src/point_in_polygon_test_unit.sv =====
// Top level of the point-in-polygon test unit.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): with func = 0 a word appends
// one vertex to the polygon table (restart = 1 empties the table and clears the
// overflow flag first); vertices beyond MaxVertices are dropped and set the flag.
// With func = 1 a word is a query point, answered by the even-odd rule.
// Output channel (out_valid_o / out_ready_i / out_data_o): one word per query,
// none per vertex load, in order of acceptance.
// A vertex load passes the front register and the queue before it is written to the
// table, and the idle back end takes one load per cycle. A query occupies the back
// end while it reads one vertex per cycle from its single-port table RAM, closes the
// last edge to the first and drains a four-stage crossing pipeline (pairing,
// differences, products, compare). With fewer than two vertices the answer is
// outside.
// A front register and a two-word queue take further words while the back end
// works or while a result waits in the output register for a stalled receiver.
// Reset empties the table and clears the overflow flag; no clearing pass.
`default_nettype none
`include "point_in_polygon_test_unit_assert.svh"

module point_in_polygon_test_unit #(
  parameter int unsigned MaxVertices = ppt_pkg::MAX_VERTICES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ppt_pkg::in_word_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output ppt_pkg::out_word_t      out_data_o
);
  import ppt_pkg::*;

  logic       push_valid, push_ready, cmd_valid, cmd_pop;
  cmd_t       push_cmd, cmd;
  back_stat_t stat;

  ppt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_cmd)
  );

  ppt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_cmd),
    .pop_valid_o (cmd_valid),
    .pop_i       (cmd_pop),
    .pop_data_o  (cmd)
  );

  ppt_back #(
    .MaxVertices(MaxVertices)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .stat_o     (stat)
  );

  `PPT_ASSERT_NEVER(a_count_bound, stat.over, "vertex count beyond table depth")
  `PPT_ASSERT_IMPL(a_ovf_full, stat.ovf, stat.full, "overflow flag set with room left")
  `PPT_ASSERT_IMPL(a_no_pop_busy, stat.busy, !stat.pop, "command popped during a query")

endmodule

`default_nettype wire

// ===== src/ppt_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none

module ppt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/ppt_front.sv =====
// Front stage: accept input words and classify them into commands.
`default_nettype none

module ppt_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ppt_pkg::in_word_t in_data_i,
  output logic                   push_valid_o,
  input  wire logic              push_ready_i,
  output ppt_pkg::cmd_t          push_data_o
);
  import ppt_pkg::*;

  logic fr_v_q;
  cmd_t fr_cmd_q, fr_cmd_d;
  logic accept;

  assign in_ready_o = !fr_v_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    fr_cmd_d.pt.x = in_data_i.coord_x;
    fr_cmd_d.pt.y = in_data_i.coord_y;
    if (in_data_i.func) begin
      fr_cmd_d.op = OP_QUERY;
    end else if (in_data_i.restart) begin
      fr_cmd_d.op = OP_RESTART;
    end else begin
      fr_cmd_d.op = OP_APPEND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_v_q <= 1'b0;
    end else if (accept) begin
      fr_v_q <= 1'b1;
    end else if (push_ready_i) begin
      fr_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fr_cmd_q <= fr_cmd_d;
    end
  end

  assign push_valid_o = fr_v_q;
  assign push_data_o  = fr_cmd_q;

endmodule

`default_nettype wire

// ===== src/ppt_queue.sv =====
// Short command queue between front and back.
`default_nettype none

module ppt_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire ppt_pkg::cmd_t push_data_i,
  output logic               pop_valid_o,
  input  wire logic          pop_i,
  output ppt_pkg::cmd_t      pop_data_o
);
  import ppt_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned LvlW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [LvlW-1:0] level_q;
  logic            do_push, do_pop;

  assign push_ready_o = level_q != LvlW'(QUEUE_DEPTH);
  assign pop_valid_o  = level_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = slot_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] wrap_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        level_q <= level_q + LvlW'(1);
      end else if (do_pop && !do_push) begin
        level_q <= level_q - LvlW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/ppt_back.sv =====
// Back end: vertex table, edge walker with crossing pipeline, result register.
`default_nettype none

module ppt_back #(
  parameter int unsigned MaxVertices = ppt_pkg::MAX_VERTICES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire ppt_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ppt_pkg::out_word_t out_data_o,
  output ppt_pkg::back_stat_t stat_o
);
  import ppt_pkg::*;

  localparam int unsigned AW = $clog2(MaxVertices);
  localparam int unsigned CW = $clog2(MaxVertices + 1);
  localparam int unsigned DW = COORD_W + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned VW = $bits(vertex_t);

  state_e state_q, state_d;
  logic [CW-1:0] count_q, tok_q, count_base;
  logic          ovf_q, inside_q, out_v_q, room;
  logic signed [COORD_W-1:0] px_q, py_q;
  out_word_t     out_q;

  // control outputs of the sequencer
  logic          mem_we, mem_re, issue, q_start, load_cmd, out_load;
  logic [AW-1:0] mem_addr;
  logic [VW-1:0] mem_rdata;

  // edge pipeline
  logic    t_v_q, t_first_q, t_close_q;
  vertex_t first_q, prev_q, cur_v, e_a_q, e_b_q;
  logic    e_v_q, m_v_q, c_v_q, m_dypos_q, c_dypos_q, straddle, dypos_d, hit;
  logic signed [DW-1:0] dx1_d, dy_d, dxe_d, dpy_d, dx1_q, dy_q, dxe_q, dpy_q;
  logic signed [PW-1:0] p1_d, p2_d, p1_q, p2_q;

  function automatic logic signed [DW-1:0] sx(logic signed [COORD_W-1:0] v);
    return {v[COORD_W-1], v};
  endfunction

  assign count_base = (cmd_i.op == OP_RESTART) ? '0 : count_q;
  assign room       = count_base < CW'(MaxVertices);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && cmd_i.op == OP_QUERY) begin
          state_d = (count_q < CW'(2)) ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        if (tok_q == count_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!(t_v_q || e_v_q || m_v_q || c_v_q)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_v_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    issue     = 1'b0;
    q_start   = 1'b0;
    load_cmd  = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        if (cmd_valid_i) begin
          if (cmd_i.op == OP_QUERY) begin
            q_start = 1'b1;
          end else begin
            load_cmd = 1'b1;
            mem_we   = room;
          end
        end
      end
      ST_WALK: begin
        issue  = 1'b1;
        mem_re = tok_q != count_q;
      end
      ST_DRAIN: begin
      end
      ST_DONE: begin
        out_load = !out_v_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  assign mem_addr = mem_we ? count_base[AW-1:0] : tok_q[AW-1:0];

  ppt_ram #(
    .Width(VW),
    .Depth(MaxVertices)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(cmd_i.pt),
    .rdata_o(mem_rdata)
  );

  // stage 1: pair the current vertex with the previous one; close back to the first
  assign cur_v = t_close_q ? first_q : vertex_t'(mem_rdata);

  // stage 2: straddle test and differences
  assign straddle = (e_a_q.y > py_q) != (e_b_q.y > py_q);
  assign dx1_d    = sx(px_q) - sx(e_a_q.x);
  assign dy_d     = sx(e_b_q.y) - sx(e_a_q.y);
  assign dxe_d    = sx(e_b_q.x) - sx(e_a_q.x);
  assign dpy_d    = sx(py_q) - sx(e_a_q.y);
  assign dypos_d  = !dy_d[DW-1] && (dy_d != '0);

  // stage 3: cross products
  assign p1_d = dx1_q * dy_q;
  assign p2_d = dxe_q * dpy_q;

  // stage 4: compare direction follows the sign of the y extent
  assign hit = c_dypos_q ? (p1_q < p2_q) : (p2_q < p1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      tok_q     <= '0;
      inside_q  <= 1'b0;
      out_v_q   <= 1'b0;
      t_v_q     <= 1'b0;
      t_first_q <= 1'b0;
      t_close_q <= 1'b0;
      e_v_q     <= 1'b0;
      m_v_q     <= 1'b0;
      c_v_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_cmd) begin
        count_q <= room ? count_base + CW'(1) : count_base;
        ovf_q   <= ((cmd_i.op == OP_RESTART) ? 1'b0 : ovf_q) | !room;
      end
      if (q_start) begin
        tok_q <= '0;
      end else if (issue) begin
        tok_q <= tok_q + CW'(1);
      end
      t_v_q     <= issue;
      t_first_q <= issue && (tok_q == '0);
      t_close_q <= issue && (tok_q == count_q);
      e_v_q     <= t_v_q && !t_first_q;
      m_v_q     <= e_v_q && straddle;
      c_v_q     <= m_v_q;
      if (q_start) begin
        inside_q <= 1'b0;
      end else if (c_v_q && hit) begin
        inside_q <= !inside_q;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_start) begin
      px_q <= cmd_i.pt.x;
      py_q <= cmd_i.pt.y;
    end
    if (t_v_q) begin
      prev_q <= cur_v;
      e_a_q  <= prev_q;
      e_b_q  <= cur_v;
      if (t_first_q) begin
        first_q <= cur_v;
      end
    end
    dx1_q     <= dx1_d;
    dy_q      <= dy_d;
    dxe_q     <= dxe_d;
    dpy_q     <= dpy_d;
    m_dypos_q <= dypos_d;
    p1_q      <= p1_d;
    p2_q      <= p2_d;
    c_dypos_q <= m_dypos_q;
    if (out_load) begin
      out_q.inside_res <= inside_q;
      out_q.overflowed <= ovf_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  assign stat_o.busy = state_q != ST_IDLE;
  assign stat_o.pop  = cmd_pop_o;
  assign stat_o.full = count_q == CW'(MaxVertices);
  assign stat_o.over = count_q > CW'(MaxVertices);
  assign stat_o.ovf  = ovf_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench of the point-in-polygon test unit: vertex loads and queries, even-odd predictor.
module tb;
  import ppt_pkg::*;

  localparam logic        FUNC_VERTEX = 1'b0;
  localparam logic        FUNC_QUERY  = 1'b1;
  localparam int unsigned TABLE_DEPTH = MAX_VERTICES_DEF;
  localparam int unsigned IDLE_LIMIT  = 3000;
  localparam int unsigned TAIL_CYCLES = 120;
  localparam int unsigned WORD_TARGET = 440;
  localparam int unsigned CALM_AFTER  = 400;

  class polygon_scoreboard;
    logic signed [COORD_W-1:0] corner_x[TABLE_DEPTH];
    logic signed [COORD_W-1:0] corner_y[TABLE_DEPTH];
    int unsigned               corner_count;
    bit                        dropped;
    out_word_t                 pending[$];
    int unsigned               fault_count;

    function new();
      corner_count = 0;
      dropped      = 0;
      fault_count  = 0;
    endfunction

    // Even-odd parity of edge crossings right of the point, with exact cross-multiplication.
    function bit crossing_parity(logic signed [COORD_W-1:0] qx, logic signed [COORD_W-1:0] qy);
      longint      px, py, x1, y1, x2, y2, dy;
      int unsigned j;
      bit          odd;
      bit          hit;
      odd = 0;
      px  = qx;
      py  = qy;
      if (corner_count < 2) return 0;
      for (int unsigned i = 0; i < corner_count; i++) begin
        j  = (i + 1 == corner_count) ? 0 : i + 1;
        x1 = corner_x[i];
        y1 = corner_y[i];
        x2 = corner_x[j];
        y2 = corner_y[j];
        if ((y1 > py) != (y2 > py)) begin
          dy = y2 - y1;
          if (dy > 0) hit = (px - x1) * dy < (x2 - x1) * (py - y1);
          else        hit = (x2 - x1) * (py - y1) < (px - x1) * dy;
          if (hit) odd = !odd;
        end
      end
      return odd;
    endfunction

    function void note_word(in_word_t w);
      out_word_t res;
      if (w.func == FUNC_VERTEX) begin
        if (w.restart) begin
          corner_count = 0;
          dropped      = 0;
        end
        if (corner_count < TABLE_DEPTH) begin
          corner_x[corner_count] = w.coord_x;
          corner_y[corner_count] = w.coord_y;
          corner_count++;
        end else begin
          dropped = 1;
        end
      end else begin
        res.inside_res = crossing_parity(w.coord_x, w.coord_y);
        res.overflowed = dropped;
        pending.insert(pending.size(), res);
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        $error("result word %b arrived with no query waiting", got);
        fault_count++;
        return;
      end
      want = pending.pop_front();
      if (got.inside_res !== want.inside_res) begin
        $error("inside_res: expected %0b, actual %0b", want.inside_res, got.inside_res);
        fault_count++;
      end
      if (got.overflowed !== want.overflowed) begin
        $error("overflowed: expected %0b, actual %0b", want.overflowed, got.overflowed);
        fault_count++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_data_o;

  polygon_scoreboard sb = new();
  int unsigned       idle_cycles = 0;
  int unsigned       sent;
  bit                calm;
  bit                gaps_on;

  point_in_polygon_test_unit #(
    .MaxVertices(TABLE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Track accepted words on both channels and watch for a stalled run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (in_valid_i && in_ready_o) sb.note_word(in_data_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: stall in bursts, hold ready high once the run turns calm.
  initial begin : ready_driver
    int unsigned span;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (calm) begin
        out_ready_i <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        span = $urandom_range(1, 19);
        out_ready_i <= 1'b0;
        repeat (span - 1) @(negedge clk_i);
      end else begin
        span = $urandom_range(1, 40);
        out_ready_i <= 1'b1;
        repeat (span - 1) @(negedge clk_i);
      end
    end
  end

  function automatic in_word_t make_word(logic f, logic r, int x, int y);
    in_word_t w;
    w.func    = f;
    w.restart = r;
    w.coord_x = x[COORD_W-1:0];
    w.coord_y = y[COORD_W-1:0];
    return w;
  endfunction

  function automatic int rand_coord(int unsigned spread);
    if (spread >= 32768) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 2 * spread)) - int'(spread);
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(in_word_t w);
    int unsigned gap;
    if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
    if (sent >= CALM_AFTER) calm = 1;
  endtask

  task automatic run_polygon(bit force_full);
    int          cx[72];
    int          cy[72];
    int unsigned sides, queries, spread, pick, k;
    int          qx, qy;
    case ($urandom_range(0, 3))
      0:       spread = 40;
      1:       spread = 1000;
      2:       spread = 20000;
      default: spread = 32768;
    endcase
    pick = $urandom_range(0, 19);
    if (force_full || pick == 0) sides = $urandom_range(60, 70);
    else if (pick == 1)          sides = $urandom_range(0, 2);
    else                         sides = $urandom_range(3, 10);
    gaps_on = ($urandom_range(0, 3) != 0);
    for (int unsigned i = 0; i < sides; i++) begin
      cx[i] = rand_coord(spread);
      cy[i] = rand_coord(spread);
      // first vertex usually restarts; rarely restart mid-polygon or append to the old one
      send_word(make_word(FUNC_VERTEX,
                          (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 39) == 0),
                          cx[i], cy[i]));
    end
    queries = $urandom_range(2, 6);
    for (int unsigned i = 0; i < queries; i++) begin
      k  = (sides > 0) ? $urandom_range(0, sides - 1) : 0;
      qx = rand_coord(spread);
      qy = rand_coord(spread);
      if (sides > 0) begin
        case ($urandom_range(0, 5))
          0: begin
            qx = cx[k];
            qy = cy[k];
          end
          1: qx = cx[k];
          2: qy = cy[k];
          3: begin
            qx = rand_coord(32768);
            qy = rand_coord(32768);
          end
          default: ;
        endcase
      end
      send_word(make_word(FUNC_QUERY, $urandom_range(0, 1), qx, qy));
    end
  endtask

  initial begin : stimulus
    in_valid_i = 1'b0;
    in_data_i  = '0;
    rst_ni     = 1'b0;
    calm       = 0;
    gaps_on    = 1;
    sent       = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table, then a single vertex: both answer outside
    send_word(make_word(FUNC_QUERY, 1'b1, 0, 0));
    send_word(make_word(FUNC_VERTEX, 1'b1, 100, 100));
    send_word(make_word(FUNC_QUERY, 1'b0, 100, 100));
    // two vertices: the edge is walked both ways
    send_word(make_word(FUNC_VERTEX, 1'b1, 0, -100));
    send_word(make_word(FUNC_VERTEX, 1'b0, 0, 100));
    send_word(make_word(FUNC_QUERY, 1'b0, -5, 0));
    // square at the coordinate extremes, queries on edges and corners
    send_word(make_word(FUNC_VERTEX, 1'b1, -32768, -32768));
    send_word(make_word(FUNC_VERTEX, 1'b0, 32767, -32768));
    send_word(make_word(FUNC_VERTEX, 1'b0, 32767, 32767));
    send_word(make_word(FUNC_VERTEX, 1'b0, -32768, 32767));
    send_word(make_word(FUNC_QUERY, 1'b0, 0, 0));
    send_word(make_word(FUNC_QUERY, 1'b1, -32768, 0));
    send_word(make_word(FUNC_QUERY, 1'b0, 32767, 32767));
    send_word(make_word(FUNC_QUERY, 1'b0, 0, -32768));
    send_word(make_word(FUNC_QUERY, 1'b0, -32768, -32768));
    // triangle: inside, on an edge, on the apex, outside
    send_word(make_word(FUNC_VERTEX, 1'b1, -160, -160));
    send_word(make_word(FUNC_VERTEX, 1'b0, 160, -160));
    send_word(make_word(FUNC_VERTEX, 1'b0, 0, 320));
    send_word(make_word(FUNC_QUERY, 1'b0, 0, 0));
    send_word(make_word(FUNC_QUERY, 1'b0, 0, -160));
    send_word(make_word(FUNC_QUERY, 1'b0, 0, 320));
    send_word(make_word(FUNC_QUERY, 1'b0, 500, 0));
    send_word(make_word(FUNC_QUERY, 1'b0, -32768, 32767));

    // load a polygon of 60 to 70 vertices against the 64-entry table first, then random polygons
    run_polygon(1'b1);
    while (sent < WORD_TARGET) run_polygon(1'b0);
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
